[rtl/core/running_mean_and_std_dev_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the running mean and std dev core
// Same-cycle and next-cycle implication checks on clk, masked during rst.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_AND_STD_DEV_CORE_ASSERT_SVH
`define RUNNING_MEAN_AND_STD_DEV_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RMSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RMSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rmsd_pkg.sv]
// ----------------------------------------------------------------------------
// rmsd_pkg
// Widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  localparam int MAX_SAMPLES  = 64;
  localparam int SAMPLE_WIDTH = 16;

  // Q8.8 samples are held as Q8.16
  localparam int FRAC_EXT    = 8;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int COUNT_OUT_W = 7;
  localparam int STD_W       = 16;
  localparam int MEAN_W      = SAMPLE_WIDTH + FRAC_EXT;
  localparam int DELTA_W     = MEAN_W + 1;
  localparam int SQ_W        = 2 * DELTA_W;
  localparam int NUM_W       = SQ_W + CNT_W;
  localparam int SUM_W       = 48;
  localparam int SQRT_W      = SUM_W / 2;
  localparam int TERM_SHIFT  = 16;

  // divider retires this many quotient bits per cycle
  localparam int DIV_RADIX_BITS = 4;
  localparam int MEAN_STEPS = (DELTA_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int TERM_STEPS = (NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int VAR_STEPS  = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_STEPS  = (TERM_STEPS > VAR_STEPS) ? TERM_STEPS : VAR_STEPS;
  localparam int DIV_W      = DIV_STEPS * DIV_RADIX_BITS;
  localparam int DSTEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [STD_W-1:0] STD_MAX = '1;

  // divider operand select
  localparam logic [1:0] DIV_SEL_MEAN = 2'd0;
  localparam logic [1:0] DIV_SEL_TERM = 2'd1;
  localparam logic [1:0] DIV_SEL_VAR  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mag;
    logic       square;
    logic       prod;
    logic       div_start;
    logic [1:0] div_sel;
    logic       mean_upd;
    logic       sum_upd;
    logic       sqrt_start;
    logic       out_load;
  } rmsd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic set_end;
    logic out_busy;
  } rmsd_status_t;

endpackage

[rtl/core/running_mean_and_std_dev_core.sv]
// ----------------------------------------------------------------------------
// running_mean_and_std_dev_core
// Welford running mean and population standard deviation over sample sets.
// ----------------------------------------------------------------------------
// Takes signed Q8.8 samples and, on the sample flagged last or the one that
// brings a set to MAX_SAMPLES (64), gives one result: mean and population
// standard deviation in Q8.8, the sample count and a truncated flag. One
// sample is in work at a time; in_ready is high only while the sequencer
// waits. A sample that does not close a set makes two passes through the
// shared 4-bit-a-cycle divider, for delta / count and for the squared term,
// before the next sample is accepted. A closing sample also needs a division
// for the variance and a bit-serial square root. The result waits in an
// output register, so the next set starts while it is still to be taken; a
// closing sample stalls until the previous result has been taken.
`include "running_mean_and_std_dev_core_assert.svh"

module running_mean_and_std_dev_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [rmsd_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                     last,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [rmsd_pkg::SAMPLE_WIDTH-1:0] mean,
  output logic [rmsd_pkg::STD_W-1:0]               std_dev,
  output logic [rmsd_pkg::COUNT_OUT_W-1:0]         sample_count,
  output logic                                     truncated
);
  import rmsd_pkg::*;

  rmsd_cmd_t    cmd;
  rmsd_status_t status;

  rmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rmsd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean         (mean),
    .std_dev      (std_dev),
    .sample_count (sample_count),
    .truncated    (truncated)
  );

  `RMSD_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(out_valid && !out_ready), "result overwritten before taken")
  `RMSD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken while busy")
  `RMSD_ASSERT_SAME(a_count_nonzero, out_valid, sample_count != '0, "result with zero sample count")
  `RMSD_ASSERT_SAME(a_trunc_full, out_valid && truncated, sample_count == COUNT_OUT_W'(MAX_SAMPLES), "truncated set not full")

endmodule

[rtl/core/rmsd_div.sv]
// ----------------------------------------------------------------------------
// rmsd_div
// Iterative restoring divider by the sample count, several bits per cycle.
// ----------------------------------------------------------------------------
module rmsd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rmsd_pkg::DIV_W-1:0]   dividend,
  input  logic [rmsd_pkg::CNT_W-1:0]   divisor,
  input  logic [rmsd_pkg::DSTEP_W-1:0] steps,
  output logic                         done,
  output logic [rmsd_pkg::DIV_W-1:0]   quotient
);
  import rmsd_pkg::*;

  logic               busy;
  logic [DSTEP_W-1:0] cnt;
  logic [DIV_W-1:0]   dvd;
  logic [DIV_W-1:0]   dvd_next;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   rem_next;

  // dividend is left-aligned; quotient bits shift in at the bottom
  always_comb begin
    logic [CNT_W:0] trial;
    dvd_next = dvd;
    rem_next = rem;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial    = {rem_next, dvd_next[DIV_W-1]};
      dvd_next = {dvd_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = CNT_W'(trial - {1'b0, divisor});
        dvd_next[0] = 1'b1;
      end else begin
        rem_next = trial[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - DSTEP_W'(1);
        if (cnt == DSTEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign quotient = dvd;

endmodule

[rtl/core/rmsd_sqrt.sv]
// ----------------------------------------------------------------------------
// rmsd_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmsd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rmsd_pkg::SUM_W-1:0]  value,
  output logic                        done,
  output logic [rmsd_pkg::SQRT_W-1:0] root
);
  import rmsd_pkg::*;

  localparam int REM_W  = SQRT_W + 2;
  localparam int SCNT_W = $clog2(SQRT_W + 1);

  logic              busy;
  logic [SCNT_W-1:0] cnt;
  logic [SUM_W-1:0]  val;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_next;
  logic [SQRT_W-1:0] root_next;
  logic [REM_W+1:0]  shifted;
  logic [REM_W+1:0]  trial;

  always_comb begin
    shifted = {rem, val[SUM_W-1:SUM_W-2]};
    trial   = (REM_W + 2)'({root, 2'b01});
    if (shifted >= trial) begin
      rem_next  = REM_W'(shifted - trial);
      root_next = {root[SQRT_W-2:0], 1'b1};
    end else begin
      rem_next  = shifted[REM_W-1:0];
      root_next = {root[SQRT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SCNT_W'(SQRT_W);
      end else if (busy) begin
        cnt <= cnt - SCNT_W'(1);
        if (cnt == SCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[SUM_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

[rtl/core/rmsd_datapath.sv]
// ----------------------------------------------------------------------------
// rmsd_datapath
// Welford state, delta/square/product stages, divider, root and result reg.
// ----------------------------------------------------------------------------
module rmsd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  rmsd_pkg::rmsd_cmd_t                 cmd,
  output rmsd_pkg::rmsd_status_t              status,
  input  logic signed [rmsd_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rmsd_pkg::SAMPLE_WIDTH-1:0] mean,
  output logic [rmsd_pkg::STD_W-1:0]          std_dev,
  output logic [rmsd_pkg::COUNT_OUT_W-1:0]    sample_count,
  output logic                                truncated
);
  import rmsd_pkg::*;

  // Welford state
  logic [CNT_W-1:0]         seen_count;
  logic signed [MEAN_W-1:0] running_mean;
  logic [SUM_W-1:0]         squared_dev_sum;

  // per-item working registers
  logic [CNT_W-1:0]          k;
  logic                      last_r;
  logic signed [DELTA_W-1:0] delta;
  logic [DELTA_W-1:0]        mag;
  logic                      neg;
  logic [SQ_W-1:0]           sq;
  logic [NUM_W-1:0]          prod;

  logic [MEAN_W-1:0]         x;
  logic                      full;
  logic [DIV_W-1:0]          div_dividend;
  logic [DSTEP_W-1:0]        div_steps;
  logic                      div_done;
  logic [DIV_W-1:0]          div_q;
  logic                      sqrt_done;
  logic [SQRT_W-1:0]         root;
  logic signed [DELTA_W-1:0] mean_step;
  logic signed [DELTA_W-1:0] mean_wide;
  logic [DIV_W-1:0]          term;
  logic [SUM_W-1:0]          room;

  assign x    = {sample, FRAC_EXT'(0)};
  assign full = (k >= CNT_W'(MAX_SAMPLES));

  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_MEAN: begin
        div_dividend = DIV_W'(mag) << (DIV_W - DIV_RADIX_BITS * MEAN_STEPS);
        div_steps    = DSTEP_W'(MEAN_STEPS);
      end
      DIV_SEL_TERM: begin
        div_dividend = DIV_W'(prod) << (DIV_W - DIV_RADIX_BITS * TERM_STEPS);
        div_steps    = DSTEP_W'(TERM_STEPS);
      end
      DIV_SEL_VAR: begin
        div_dividend = DIV_W'(squared_dev_sum) << (DIV_W - DIV_RADIX_BITS * VAR_STEPS);
        div_steps    = DSTEP_W'(VAR_STEPS);
      end
      default: begin
        div_dividend = '0;
        div_steps    = DSTEP_W'(1);
      end
    endcase
  end

  rmsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (k),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  rmsd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .value (div_q[SUM_W-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  // delta / k rounds toward zero: divide the magnitude, restore the sign
  always_comb begin
    mean_step = neg ? -$signed(div_q[DELTA_W-1:0]) : $signed(div_q[DELTA_W-1:0]);
    mean_wide = $signed({running_mean[MEAN_W-1], running_mean}) + mean_step;
    term      = div_q >> TERM_SHIFT;
    room      = SUM_MAX - squared_dev_sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k      <= seen_count + CNT_W'(1);
      last_r <= last;
      delta  <= $signed({x[MEAN_W-1], x}) - $signed({running_mean[MEAN_W-1], running_mean});
    end
    if (cmd.mag) begin
      neg <= delta[DELTA_W-1];
      mag <= delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
    end
    if (cmd.square) begin
      sq <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (cmd.prod) begin
      prod <= NUM_W'(k - CNT_W'(1)) * NUM_W'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count      <= '0;
      running_mean    <= '0;
      squared_dev_sum <= '0;
    end else if (cmd.out_load) begin
      seen_count      <= '0;
      running_mean    <= '0;
      squared_dev_sum <= '0;
    end else begin
      if (cmd.mean_upd) begin
        running_mean <= mean_wide[MEAN_W-1:0];
      end
      if (cmd.sum_upd) begin
        seen_count <= k;
        if (term > DIV_W'(room)) begin
          squared_dev_sum <= SUM_MAX;
        end else begin
          squared_dev_sum <= squared_dev_sum + SUM_W'(term);
        end
      end
    end
  end

  // result register: holds a finished set while the next one is worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean         <= running_mean[MEAN_W-1:FRAC_EXT];
      std_dev      <= (root > SQRT_W'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
      sample_count <= COUNT_OUT_W'(k);
      truncated    <= full & ~last_r;
    end
  end

  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;
  assign status.set_end   = last_r | full;
  assign status.out_busy  = out_valid & ~out_ready;

endmodule

[rtl/core/rmsd_ctrl.sv]
// ----------------------------------------------------------------------------
// rmsd_ctrl
// Sequencer: steps the datapath through one sample and the end-of-set result.
// ----------------------------------------------------------------------------
module rmsd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rmsd_pkg::rmsd_status_t status,
  output rmsd_pkg::rmsd_cmd_t    cmd
);
  import rmsd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAG  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_PROD = 4'd3;
  localparam logic [3:0] S_DIVM = 4'd4;
  localparam logic [3:0] S_DIVT = 4'd5;
  localparam logic [3:0] S_VAR  = 4'd6;
  localparam logic [3:0] S_DIVV = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_SEL_MEAN;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.square    = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_MEAN;
        state_next    = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_DIVM;
      end
      S_DIVM: begin
        if (status.div_done) begin
          cmd.mean_upd  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_TERM;
          state_next    = S_DIVT;
        end
      end
      S_DIVT: begin
        if (status.div_done) begin
          cmd.sum_upd = 1'b1;
          state_next  = status.set_end ? S_VAR : S_IDLE;
        end
      end
      S_VAR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_VAR;
        state_next    = S_DIVV;
      end
      S_DIVV: begin
        if (status.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (status.sqrt_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the result register to be free
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
